>>> sv/canseg_pkg.sv
// ----------------------------------------------------------------------------
// canseg_pkg
// Shared types and codes of the CAN segment reassembler.
// ----------------------------------------------------------------------------
package canseg_pkg;

	localparam int FRAME_ID_W   = 29;
	localparam int FRAME_LEN_W  = 4;
	localparam int DATA_W       = 64;
	localparam int TOTAL_W      = 7;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 8;
	localparam int LANES        = 8;

	localparam logic [1:0] ROLE_NONE   = 2'd0;
	localparam logic [1:0] ROLE_FIRST  = 2'd1;
	localparam logic [1:0] ROLE_MIDDLE = 2'd2;
	localparam logic [1:0] ROLE_FINAL  = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] CFG_STATION_ID = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOST_MODE  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FUNC_CODE  = 2'd2;

	localparam logic [FRAME_LEN_W-1:0] MAX_LEN = 4'd8;

	typedef struct packed {
		logic [FRAME_ID_W-1:0]  frame_id;
		logic [FRAME_LEN_W-1:0] frame_len;
		logic [DATA_W-1:0]      frame_data;
	} frame_t;

	typedef struct packed {
		logic [DATA_W-1:0]      msg_word;
		logic [FRAME_LEN_W-1:0] word_bytes;
		logic                   msg_last;
		logic [TOTAL_W-1:0]     msg_total;
	} msg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROC,
		ST_READ,
		ST_LOAD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_frame;
		logic process;
		logic load_word;
		logic next_word;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic last;
	} sts_t;

endpackage

>>> sv/can_segment_reassembler.sv
// ----------------------------------------------------------------------------
// can_segment_reassembler
// Filters received CAN extended frames and reassembles segmented messages,
// emitting each finished message as 8-byte words.
// Timing: an accepted frame is decoded and written to the buffer in the next
// cycle; a frame that gives no words then frees the intake again. Each word of
// a finished message takes a buffer read, an output load and a handshake, and
// the next word is read only after that handshake; msg_stall holds it.
// Reset clears configuration and message state; buffer contents are undefined.
// ----------------------------------------------------------------------------
module can_segment_reassembler import canseg_pkg::*; #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   frame_valid,
	output logic                   frame_stall,
	input  frame_t                 frame,
	output logic                   msg_valid,
	input  logic                   msg_stall,
	output msg_t                   msg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	canseg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	canseg_dp #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.frame    (frame),
		.msg      (msg),
		.cmd      (cmd),
		.sts      (sts)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_stall |=> frame_stall)
		else $error("intake open in the cycle after a transaction");

	a_no_intake_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid |-> frame_stall)
		else $error("intake open while a word is presented");

	a_word_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid |-> msg.word_bytes <= 4'd8)
		else $error("word byte count above eight");

	a_full_inner_words: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg.msg_last |-> msg.word_bytes == 4'd8)
		else $error("partial word before the end of a message");

endmodule

>>> sv/canseg_ram.sv
// ----------------------------------------------------------------------------
// canseg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module canseg_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/canseg_ctrl.sv
// ----------------------------------------------------------------------------
// canseg_ctrl
// Sequencer: intake, frame processing and word-by-word message readout.
// ----------------------------------------------------------------------------
module canseg_ctrl import canseg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic frame_valid,
	output logic frame_stall,
	output logic msg_valid,
	input  logic msg_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		frame_stall = 1'b1;
		msg_valid   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				frame_stall = 1'b0;
				if (frame_valid) begin
					cmd.load_frame = 1'b1;
					state_d        = ST_PROC;
				end
			end
			ST_PROC: begin
				cmd.process = 1'b1;
				state_d     = sts.emit ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_word = 1'b1;
				state_d       = ST_OUT;
			end
			ST_OUT: begin
				msg_valid = 1'b1;
				if (!msg_stall) begin
					if (sts.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next_word = 1'b1;
						state_d       = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/canseg_dp.sv
// ----------------------------------------------------------------------------
// canseg_dp
// Datapath: configuration, frame decode, message state and byte-lane buffer.
// ----------------------------------------------------------------------------
module canseg_dp import canseg_pkg::*; #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  frame_t                 frame,
	output msg_t                   msg,
	input  cmd_t                   cmd,
	output sts_t                   sts
);

	localparam int CW   = $clog2(BUFFER_BYTES + 1);
	localparam int ROWS = (BUFFER_BYTES + LANES - 1) / LANES;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [7:0]    station_id_q;
	logic          host_mode_q;
	logic [3:0]    func_code_q;
	logic          in_progress_q;
	logic [7:0]    last_seq_q;
	logic [CW-1:0] byte_count_q;

	frame_t        frame_q;
	logic [CW-1:0] rem_q;
	logic [RW-1:0] word_q;
	msg_t          msg_q;

	logic [1:0]             role;
	logic [7:0]             seq;
	logic [FRAME_LEN_W-1:0] len;
	logic                   match;
	logic                   seq_ok;
	logic                   fit_ok;
	logic                   ok;
	logic                   wr_en;
	logic [CW-1:0]          wr_base;
	logic [CW:0]            sum;
	logic [CW-1:0]          total;
	logic [FRAME_LEN_W-1:0] word_n;
	logic [DATA_W-1:0]      rd_word;

	// total = remaining bytes plus bytes already sent in earlier words
	function automatic logic [CW+RW+3:0] total_hold(input logic [CW-1:0] rem,
		input logic [RW-1:0] row);
		total_hold = (CW + RW + 4)'(rem) + ((CW + RW + 4)'(row) << 3);
	endfunction

	always_comb begin
		role   = frame_q.frame_id[21:20];
		seq    = frame_q.frame_id[19:12];
		len    = (frame_q.frame_len > MAX_LEN) ? MAX_LEN : frame_q.frame_len;
		match  = (frame_q.frame_id[11:8] == func_code_q) &&
		         ((frame_q.frame_id[7:0] == station_id_q) || host_mode_q);
		seq_ok = ({1'b0, seq} == ({1'b0, last_seq_q} + 9'd1));
		sum    = {1'b0, byte_count_q} + (CW + 1)'(len);
		fit_ok = (sum <= (CW + 1)'(BUFFER_BYTES));
		ok     = in_progress_q && seq_ok && fit_ok;
		wr_en  = match && ((role == ROLE_NONE) || (role == ROLE_FIRST) || ok);
		if ((role == ROLE_NONE) || (role == ROLE_FIRST)) begin
			wr_base = '0;
			total   = CW'(len);
		end else begin
			wr_base = byte_count_q;
			total   = sum[CW-1:0];
		end
		sts.emit = match && ((role == ROLE_NONE) || ((role == ROLE_FINAL) && ok));
		sts.last = (rem_q <= CW'(LANES));
		word_n   = (rem_q > CW'(LANES)) ? MAX_LEN : rem_q[FRAME_LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_id_q  <= '0;
			host_mode_q   <= 1'b0;
			func_code_q   <= '0;
			in_progress_q <= 1'b0;
			last_seq_q    <= '0;
			byte_count_q  <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_STATION_ID: station_id_q <= cfg_data;
					CFG_HOST_MODE:  host_mode_q  <= cfg_data[0];
					CFG_FUNC_CODE:  func_code_q  <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (cmd.process && match) begin
				case (role)
					ROLE_FIRST: begin
						in_progress_q <= 1'b1;
						last_seq_q    <= seq;
						byte_count_q  <= CW'(len);
					end
					ROLE_MIDDLE: begin
						if (ok) begin
							last_seq_q   <= last_seq_q + 8'd1;
							byte_count_q <= sum[CW-1:0];
						end
					end
					ROLE_FINAL: begin
						if (ok) begin
							in_progress_q <= 1'b0;
							last_seq_q    <= '0;
							byte_count_q  <= '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_frame) begin
			frame_q <= frame;
		end
		if (cmd.process) begin
			rem_q  <= total;
			word_q <= '0;
		end else if (cmd.next_word) begin
			rem_q  <= rem_q - CW'(LANES);
			word_q <= word_q + RW'(1);
		end
		if (cmd.load_word) begin
			msg_q.msg_word   <= rd_word;
			msg_q.word_bytes <= word_n;
			msg_q.msg_last   <= sts.last;
			msg_q.msg_total  <= TOTAL_W'(total_hold(rem_q, word_q));
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		logic [2:0]    pos;
		logic [CW:0]   addr;
		logic          we;
		logic [7:0]    rdata;

		always_comb begin
			pos  = 3'(g) - wr_base[2:0];
			addr = {1'b0, wr_base} + (CW + 1)'(pos);
			we   = cmd.process && wr_en && ({1'b0, pos} < len) &&
			       (addr < (CW + 1)'(BUFFER_BYTES));
		end

		assign rd_word[8*g +: 8] = (g < word_n) ? rdata : 8'd0;

		canseg_ram #(
			.WIDTH (8),
			.DEPTH (ROWS),
			.ADDR_W(RW)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(RW'(addr >> 3)),
			.wdata(8'(frame_q.frame_data >> (8 * pos))),
			.raddr(word_q),
			.rdata(rdata)
		);
	end

	assign msg = msg_q;

endmodule

>>> verif/tb_can_segment_reassembler.sv
// ----------------------------------------------------------------------------
// tb_can_segment_reassembler
// Drives CAN extended frames into the segment reassembler under random idling
// on both sides and checks every emitted message word against a predictor
// that tracks the station filter, the open segmented message and its buffer.
// ----------------------------------------------------------------------------
module tb_can_segment_reassembler;
	import canseg_pkg::*;

	localparam int MSG_BYTES     = 64;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 2000;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   frame_valid;
	logic                   frame_stall;
	frame_t                 frame;
	logic                   msg_valid;
	logic                   msg_stall;
	msg_t                   msg;

	// predictor state
	logic [7:0] cfg_station = '0;
	bit         cfg_host    = 1'b0;
	logic [3:0] cfg_func    = '0;
	bit         open_msg    = 1'b0;
	int         prev_seq    = 0;
	int         fill        = 0;
	logic [7:0] msg_bytes [MSG_BYTES];
	msg_t       pending_words [$];

	int errors      = 0;
	int idle_cycles = 0;
	bit tx_calm     = 1'b0;
	bit rx_calm     = 1'b0;
	bit long_hold   = 1'b0;
	bit rx_holding  = 1'b0;

	can_segment_reassembler #(.BUFFER_BYTES(MSG_BYTES)) uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned idle_len(int unsigned floor);
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(floor, 3);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic frame_t make_frame(logic [1:0] role, logic [7:0] seq, logic [3:0] func,
			logic [7:0] src, logic [3:0] len, logic [63:0] data);
		frame_t     f;
		logic [6:0] spare;
		spare = 7'($urandom_range(0, 127));
		f.frame_id   = {spare, role, seq, func, src};
		f.frame_len  = len;
		f.frame_data = data;
		return f;
	endfunction

	function automatic frame_t match_frame(logic [1:0] role, logic [7:0] seq, logic [3:0] len);
		logic [7:0] src;
		src = cfg_host ? 8'($urandom_range(0, 255)) : cfg_station;
		return make_frame(role, seq, cfg_func, src, len, rand64());
	endfunction

	task automatic store_bytes(int at, logic [63:0] data, int len);
		for (int b = 0; b < len; b++)
			if (at + b < MSG_BYTES)
				msg_bytes[at + b] = data[8*b +: 8];
	endtask

	task automatic emit_message(int total);
		int   words;
		int   n;
		msg_t w;
		words = (total + 7) / 8;
		if (words == 0)
			words = 1;
		for (int k = 0; k < words; k++) begin
			n = total - 8 * k;
			if (n < 0)
				n = 0;
			if (n > 8)
				n = 8;
			w = '0;
			for (int b = 0; b < n; b++)
				w.msg_word[8*b +: 8] = msg_bytes[8*k + b];
			w.word_bytes = 4'(n);
			w.msg_last   = (k == words - 1);
			w.msg_total  = 7'(total);
			pending_words.push_back(w);
		end
	endtask

	task automatic reassemble(frame_t f);
		logic [1:0] role;
		logic [7:0] seq;
		logic [3:0] func;
		logic [7:0] src;
		int         len;
		role = f.frame_id[21:20];
		seq  = f.frame_id[19:12];
		func = f.frame_id[11:8];
		src  = f.frame_id[7:0];
		len  = (f.frame_len > MAX_LEN) ? MAX_LEN : f.frame_len;
		if (func != cfg_func || !(src == cfg_station || cfg_host))
			return;
		if (role == ROLE_NONE) begin
			store_bytes(0, f.frame_data, len);
			emit_message(len);
		end else if (role == ROLE_FIRST) begin
			store_bytes(0, f.frame_data, len);
			open_msg = 1'b1;
			prev_seq = seq;
			fill     = len;
		end else if (open_msg && seq == prev_seq + 1 && fill + len <= MSG_BYTES) begin
			store_bytes(fill, f.frame_data, len);
			if (role == ROLE_MIDDLE) begin
				prev_seq++;
				fill += len;
			end else begin
				emit_message(fill + len);
				open_msg = 1'b0;
				prev_seq = 0;
				fill     = 0;
			end
		end
	endtask

	task automatic send_frame(frame_t f);
		int unsigned gap;
		gap = tx_calm ? 0 : idle_len(0);
		if (gap != 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_valid <= 1'b1;
		frame       <= f;
		do @(posedge clk); while (frame_stall);
		reassemble(f);
	endtask

	task automatic send_message(int seq0, int middles, int lo, int hi);
		send_frame(match_frame(ROLE_FIRST, 8'(seq0), 4'($urandom_range(lo, hi))));
		for (int k = 1; k <= middles; k++)
			send_frame(match_frame(ROLE_MIDDLE, 8'(seq0 + k), 4'($urandom_range(lo, hi))));
		send_frame(match_frame(ROLE_FINAL, 8'(seq0 + middles + 1),
				4'($urandom_range(lo, hi))));
	endtask

	task automatic write_config(logic [7:0] station, bit host, logic [3:0] func);
		logic [CFG_INDEX_W-1:0] idx [3];
		logic [CFG_DATA_W-1:0]  val [3];
		idx = '{CFG_STATION_ID, CFG_HOST_MODE, CFG_FUNC_CODE};
		val = '{station, {7'd0, host}, {4'd0, func}};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid   <= 1'b0;
		cfg_station = station;
		cfg_host    = host;
		cfg_func    = func;
	endtask

	task automatic wait_idle();
		frame_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_config();
		send_frame(match_frame(ROLE_NONE, 8'd0, 4'd8));
		send_frame(make_frame(ROLE_NONE, 8'd0, 4'd0, 8'h01, 4'd5, rand64()));
	endtask

	task automatic test_directed_cases();
		wait_idle();
		write_config(8'hFF, 1'b0, 4'hF);
		send_frame(match_frame(ROLE_NONE, 8'd0, 4'd0));
		send_frame(make_frame(ROLE_NONE, 8'hFF, 4'hF, 8'hFF, 4'hF, '1));
		send_frame(make_frame(ROLE_NONE, 8'd0, 4'hF, 8'hFF, 4'd8, '0));
		send_frame(make_frame(ROLE_NONE, 8'd0, 4'hE, 8'hFF, 4'd8, rand64()));
		send_frame(make_frame(ROLE_NONE, 8'd0, 4'hF, 8'hFE, 4'd8, rand64()));
		// skipped sequence, then an unsegmented frame inside an open message
		send_frame(match_frame(ROLE_FIRST, 8'd5, 4'd3));
		send_frame(match_frame(ROLE_MIDDLE, 8'd7, 4'd8));
		send_frame(match_frame(ROLE_MIDDLE, 8'd6, 4'd8));
		send_frame(match_frame(ROLE_NONE, 8'd0, 4'd2));
		send_frame(match_frame(ROLE_FINAL, 8'd7, 4'd5));
		send_frame(match_frame(ROLE_FINAL, 8'd1, 4'd4));
		// no segment follows sequence 255
		send_frame(match_frame(ROLE_FIRST, 8'hFF, 4'd4));
		send_frame(match_frame(ROLE_MIDDLE, 8'd0, 4'd4));
		// fill the buffer, overflow on the final, then close with an empty final
		send_message(0, 7, 8, 8);
		send_frame(match_frame(ROLE_FINAL, 8'd8, 4'd0));
	endtask

	task automatic send_random(int count);
		int          sent;
		int unsigned kind;
		int          seq0;
		int          middles;
		frame_t      f;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				seq0    = ($urandom_range(0, 15) == 0) ? $urandom_range(250, 255)
						: $urandom_range(0, 240);
				middles = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8)
						: $urandom_range(0, 3);
				send_message(seq0, middles, 0, 15);
				sent += middles + 2;
			end else if (kind == 6) begin
				send_frame(match_frame(ROLE_NONE, 8'($urandom_range(0, 255)),
						4'($urandom_range(0, 15))));
				sent++;
			end else if (kind == 7) begin
				f.frame_id   = 29'($urandom);
				f.frame_len  = 4'($urandom_range(0, 15));
				f.frame_data = rand64();
				send_frame(f);
			end else if (kind == 8) begin
				send_frame(match_frame(2'($urandom_range(ROLE_MIDDLE, ROLE_FINAL)),
						8'($urandom_range(0, 255)), 4'($urandom_range(0, 15))));
				sent++;
			end else begin
				f = match_frame(ROLE_NONE, 8'd0, 4'd8);
				if ($urandom_range(0, 1) == 0)
					f.frame_id[11:8] = f.frame_id[11:8] ^ 4'($urandom_range(1, 15));
				else
					f.frame_id[7:0] = f.frame_id[7:0] ^ 8'($urandom_range(1, 255));
				send_frame(f);
			end
		end
	endtask

	task automatic test_random_traffic();
		wait_idle();
		write_config(8'($urandom_range(0, 255)), 1'b0, 4'($urandom_range(0, 15)));
		send_random(30);
		wait_idle();
		write_config(8'h00, 1'b1, 4'h0);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		send_random(20);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		wait_idle();
		write_config(8'($urandom_range(0, 255)), 1'b1, 4'($urandom_range(0, 15)));
		send_random(30);
	endtask

	task automatic test_output_backpressure();
		wait_idle();
		tx_calm   = 1'b1;
		long_hold = 1'b1;
		do @(posedge clk); while (!rx_holding);
		send_message(10, 6, 8, 8);
		for (int k = 0; k < 3; k++)
			send_frame(match_frame(ROLE_NONE, 8'd0, 4'd8));
		tx_calm = 1'b0;
	endtask

	initial begin : rx_side
		int unsigned n;
		msg_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold) begin
				long_hold  = 1'b0;
				rx_holding = 1'b1;
				msg_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_holding = 1'b0;
			end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
				msg_stall <= 1'b1;
				n = idle_len(1);
				repeat (n) @(posedge clk);
			end else begin
				msg_stall <= 1'b0;
				n = rx_calm ? 1 : $urandom_range(1, 10);
				repeat (n) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : word_check
		msg_t want;
		if (arst_n && msg_valid && !msg_stall) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, got %h", $time, msg);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (msg.msg_word !== want.msg_word) begin
					$display("%0t: msg_word expected %h, got %h", $time, want.msg_word,
							msg.msg_word);
					errors++;
				end
				if (msg.word_bytes !== want.word_bytes) begin
					$display("%0t: word_bytes expected %0d, got %0d", $time, want.word_bytes,
							msg.word_bytes);
					errors++;
				end
				if (msg.msg_last !== want.msg_last) begin
					$display("%0t: msg_last expected %b, got %b", $time, want.msg_last,
							msg.msg_last);
					errors++;
				end
				if (msg.msg_total !== want.msg_total) begin
					$display("%0t: msg_total expected %0d, got %0d", $time, want.msg_total,
							msg.msg_total);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((frame_valid && !frame_stall) || (msg_valid && !msg_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		frame_valid = 1'b0;
		frame       = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_directed_cases();
		test_random_traffic();
		test_output_backpressure();
		wait_idle();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
sv/canseg_pkg.sv
sv/canseg_ram.sv
sv/canseg_ctrl.sv
sv/canseg_dp.sv
sv/can_segment_reassembler.sv
verif/tb_can_segment_reassembler.sv
